### sv/icts_pkg.sv
// Package: shared types and constants for the IPv4 CIDR text scanner.
`timescale 1ns / 1ps
package icts_pkg;

	localparam int FULL_PREFIX = 32;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_BAD_ADDR  = 2'd1,
		ST_BAD_PFX   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ADV_LIVE       = 2'd0,
		ADV_DEAD       = 2'd1,
		ADV_END_BEFORE = 2'd2,
		ADV_END_WITH   = 2'd3
	} adv_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] range_low;
		logic [31:0] range_high;
	} out_item_t;

	// candidate as a cell presents it to the selector
	typedef struct packed {
		logic        valid;
		logic        bad;
		logic        oct;
		logic [2:0]  stage;
		logic [1:0]  cnt;
		logic [31:0] addr;
		logic [9:0]  gval;
		logic [6:0]  pfx;
	} cand_t;

	// control from the selector to every cell
	typedef struct packed {
		logic       step;
		logic       clear;
		logic       start;
		logic [7:0] ch;
	} cell_ctl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// fold one digit into a group value
	function automatic cand_t take_digit(input cand_t c, input logic [3:0] d);
		cand_t r;
		logic [13:0] v;
		r = c;
		if (c.cnt == 2'd0 && d == 4'd0)
			r.oct = 1'b1;
		if (r.oct) begin
			if (d > 4'd7)
				r.bad = 1'b1;
			v = {1'b0, c.gval, 3'b000} + {10'd0, d};
		end else begin
			v = {1'b0, c.gval, 3'b000} + {3'b000, c.gval, 1'b0} + {10'd0, d};
		end
		r.gval = v[9:0];
		r.cnt = c.cnt + 2'd1;
		return r;
	endfunction

	function automatic cand_t close_group(input cand_t c);
		cand_t r;
		r = c;
		if (c.gval > 10'd255)
			r.bad = 1'b1;
		r.addr = {c.addr[23:0], c.gval[7:0]};
		r.gval = '0;
		r.oct = 1'b0;
		r.cnt = 2'd0;
		return r;
	endfunction

	function automatic logic is_complete(input cand_t c);
		return c.valid && ((c.stage == 3'd3 && c.cnt != 2'd0) || c.stage == 3'd4 ||
			(c.stage == 3'd5 && c.cnt != 2'd0));
	endfunction

endpackage

### sv/ipv4_cidr_text_scanner.sv
// Top level: IPv4 CIDR text scanner built as a ring of candidate cells.
`timescale 1ns / 1ps
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------
//  input   | in_valid  | in_stall  | in_item  (in_item_t)
//  output  | out_valid | out_stall | out_item (out_item_t)
//
// One byte is taken per cycle unless the input stalls; every cell steps in
// that same cycle, so the sustained rate is one item per clock while the
// input is not stalled. A result appears in the output register the cycle
// after the byte that ends the match. The input stalls only while a result
// waits and the consumer stalls. Reset clears all cells, the ring slot and the output valid.
module ipv4_cidr_text_scanner
	import icts_pkg::*;
#(
	parameter int CANDIDATE_CELLS = 18
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int SW = $clog2(CANDIDATE_CELLS);

	logic [SW-1:0] slot_q;
	cand_t  cur [CANDIDATE_CELLS];
	cand_t  nxt [CANDIDATE_CELLS];
	adv_t   adv [CANDIDATE_CELLS];
	cell_ctl_t ctl [CANDIDATE_CELLS];
	logic   acc;
	logic   dig;
	logic   hit, fhit;
	logic [SW-1:0] best, fbest;
	adv_t   best_kind;
	cand_t  win;
	out_item_t res;

	// hold input while an undelivered result blocks the output register
	assign in_stall = out_valid && out_stall;
	assign acc = in_valid && !in_stall;
	assign dig = is_digit(in_item.text_byte);

	// oldest ending candidate: walk ages from the slot, oldest first
	always_comb begin
		logic [SW:0] idx;
		hit = 1'b0;
		best = '0;
		best_kind = ADV_LIVE;
		fhit = 1'b0;
		fbest = '0;
		for (int a = 0; a < CANDIDATE_CELLS; a++) begin
			idx = {1'b0, slot_q} + (SW+1)'(a);
			if (idx >= (SW+1)'(CANDIDATE_CELLS))
				idx = idx - (SW+1)'(CANDIDATE_CELLS);
			if (!hit && cur[idx[SW-1:0]].valid &&
				(adv[idx[SW-1:0]] == ADV_END_BEFORE || adv[idx[SW-1:0]] == ADV_END_WITH)) begin
				hit = 1'b1;
				best = idx[SW-1:0];
				best_kind = adv[idx[SW-1:0]];
			end
			if (!fhit && is_complete(nxt[idx[SW-1:0]]) &&
				adv[idx[SW-1:0]] != ADV_DEAD) begin
				fhit = 1'b1;
				fbest = idx[SW-1:0];
			end
		end
	end

	// report the candidate after this byte; a second prefix digit is included
	assign win = hit ? nxt[best] : nxt[fbest];
	icts_emit u_emit (.cand(win), .res(res));

	for (genvar k = 0; k < CANDIDATE_CELLS; k++) begin : g_cell
		always_comb begin
			ctl[k].step  = acc;
			ctl[k].ch    = in_item.text_byte;
			ctl[k].clear = hit || in_item.stream_end;
			ctl[k].start = dig && !in_item.stream_end && SW'(k) == slot_q &&
				(!hit || best_kind == ADV_END_BEFORE);
		end
		icts_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl[k]),
			.cur(cur[k]), .nxt(nxt[k]), .adv(adv[k])
		);
	end

	// ring slot advances per byte, returns to zero at end of stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (acc) begin
			if (in_item.stream_end)
				slot_q <= '0;
			else if (slot_q == SW'(CANDIDATE_CELLS - 1))
				slot_q <= '0;
			else
				slot_q <= slot_q + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (acc) begin
			out_valid <= hit || (in_item.stream_end && fhit);
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (hit || (in_item.stream_end && fhit)))
			out_item <= res;
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result dropped under stall");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_item.stream_end |=> slot_q == '0)
		else $error("slot not reset at stream end");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SW+1)'(CANDIDATE_CELLS))
		else $error("slot out of range");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status != 2'd3)
		else $error("bad status code");

endmodule

### sv/icts_cell.sv
// One candidate cell: tracks a match that began at one byte position.
`timescale 1ns / 1ps
module icts_cell
	import icts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	output cand_t     cur,
	output cand_t     nxt,
	output adv_t      adv
);

	cand_t cand_q;
	logic [3:0] d;
	logic dig;
	logic [10:0] p10;

	assign cur = cand_q;
	assign dig = is_digit(ctl.ch);
	assign d = ctl.ch[3:0] - 4'd0;
	assign p10 = {1'b0, cand_q.pfx, 3'b000} + {3'b000, cand_q.pfx, 1'b0} + {7'd0, d};

	// advance this candidate by one byte
	always_comb begin
		nxt = cand_q;
		adv = ADV_DEAD;
		if (cand_q.valid) begin
			if (cand_q.stage <= 3'd2) begin
				if (dig && cand_q.cnt < 2'd3) begin
					nxt = take_digit(cand_q, d);
					adv = ADV_LIVE;
				end else if (!dig && ctl.ch == 8'h2E && cand_q.cnt != 2'd0) begin
					nxt = close_group(cand_q);
					nxt.stage = cand_q.stage + 3'd1;
					adv = ADV_LIVE;
				end
			end else if (cand_q.stage == 3'd3) begin
				if (dig && cand_q.cnt < 2'd3) begin
					nxt = take_digit(cand_q, d);
					adv = ADV_LIVE;
				end else if (ctl.ch == 8'h2F && cand_q.cnt != 2'd0) begin
					nxt = close_group(cand_q);
					nxt.stage = 3'd4;
					adv = ADV_LIVE;
				end else if (cand_q.cnt != 2'd0) begin
					adv = ADV_END_BEFORE;
				end
			end else if (cand_q.stage == 3'd4) begin
				if (dig) begin
					nxt.stage = 3'd5;
					nxt.cnt = 2'd1;
					nxt.pfx = {3'd0, d};
					adv = ADV_LIVE;
				end else begin
					adv = ADV_END_BEFORE;
				end
			end else if (cand_q.stage == 3'd5) begin
				if (dig && cand_q.cnt < 2'd2) begin
					nxt.pfx = p10[6:0];
					nxt.cnt = 2'd2;
					adv = ADV_END_WITH;
				end else begin
					adv = ADV_END_BEFORE;
				end
			end
		end
	end

	// hold, advance, drop or restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (ctl.step) begin
			if (ctl.start) begin
				cand_q <= take_digit('{valid: 1'b1, default: '0}, d);
			end else if (ctl.clear || adv == ADV_DEAD) begin
				cand_q <= '0;
			end else begin
				cand_q <= nxt;
			end
		end
	end

endmodule

### sv/icts_emit.sv
// Result formatter: turns a finished candidate into status and range.
`timescale 1ns / 1ps
module icts_emit
	import icts_pkg::*;
(
	input  cand_t     cand,
	output out_item_t res
);

	cand_t c;
	logic [6:0] pfx;
	logic [31:0] mask;

	always_comb begin
		c = cand;
		if (cand.stage == 3'd3)
			c = close_group(cand);
		pfx = (cand.stage == 3'd5) ? cand.pfx : 7'(FULL_PREFIX);
		mask = (pfx == 7'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'(FULL_PREFIX) - pfx[5:0]));
		res = '0;
		if (c.bad) begin
			res.status = ST_BAD_ADDR;
		end else if (pfx > 7'(FULL_PREFIX)) begin
			res.status = ST_BAD_PFX;
		end else begin
			res.status = ST_VALID;
			res.range_low = c.addr & mask;
			res.range_high = c.addr | ~mask;
		end
	end

endmodule
